// ===== hdl/rrl_pkg.sv =====
// ----------------------------------------------------------------------------
// rrl_pkg
// Shared types and constants of the resource request ledger: table sizes,
// operation and status codes.
// ----------------------------------------------------------------------------
package rrl_pkg;

  localparam int unsigned CUSTOMERS = 8;
  localparam int unsigned RESOURCES = 4;

  localparam int unsigned AMT_W   = 8;
  localparam int unsigned CUST_W  = 3;
  localparam int unsigned AMT_N   = 4;
  localparam int unsigned FAIL_W  = 2;
  localparam int unsigned ROWS    = CUSTOMERS * RESOURCES;
  localparam int unsigned IDX_W   = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
  localparam int unsigned ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef enum logic [1:0] {
    MODE_REQUEST  = 2'd0,
    MODE_RELEASE  = 2'd1,
    MODE_LOAD_MAX = 2'd2,
    MODE_LOAD_POOL = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_AVAIL = 2'd1,
    STAT_NEED  = 2'd2,
    STAT_ALLOC = 2'd3
  } status_e;

  typedef logic [AMT_W-1:0] amt_t;

endpackage

// ===== hdl/rrl_req_if.sv =====
// ----------------------------------------------------------------------------
// rrl_req_if
// Request channel of the ledger: operation, customer and four amounts.
// ----------------------------------------------------------------------------
interface rrl_req_if
  import rrl_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [CUST_W-1:0] customer;
  logic [AMT_W-1:0]  amount_0;
  logic [AMT_W-1:0]  amount_1;
  logic [AMT_W-1:0]  amount_2;
  logic [AMT_W-1:0]  amount_3;

  modport source (
    output valid, mode, customer, amount_0, amount_1, amount_2, amount_3,
    input  ready
  );
  modport sink (
    input  valid, mode, customer, amount_0, amount_1, amount_2, amount_3,
    output ready
  );
endinterface

// ----------------------------------------------------------------------------
// rrl_rsp_if
// Response channel of the ledger: status and failing resource index.
// ----------------------------------------------------------------------------
interface rrl_rsp_if
  import rrl_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [FAIL_W-1:0] failing_resource;

  modport source (
    output valid, status, failing_resource,
    input  ready
  );
  modport sink (
    input  valid, status, failing_resource,
    output ready
  );
endinterface

// ===== hdl/resource_request_ledger_top.sv =====
// ----------------------------------------------------------------------------
// resource_request_ledger_top
// Banker's-style request/release ledger: a pool per resource and, per
// customer, held and claimable units, updated one resource per cycle by a
// shared compare and add/subtract unit under a small sequencer.
// ----------------------------------------------------------------------------
// sequence: request/release checks resources in turn in ST_CHECK, then updates
//   each in ST_UPDATE before ST_RESP; a failing check ends at once in ST_RESP;
//   loads only sweep ST_UPDATE; bar pool loads, a bad customer goes to ST_RESP
// throughput: one transaction at a time, set by the per-resource step of the
//   shared unit; the next is accepted the cycle after the response is taken
// reset: pool, held and claimable tables clear to zero at once, no sweep
// ----------------------------------------------------------------------------
module resource_request_ledger_top
  import rrl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  rrl_req_if.sink   req_i,
  rrl_rsp_if.source rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_UPDATE,
    ST_RESP
  } state_e;

  state_e                      state_q;
  logic [IDX_W-1:0]            r_q;
  logic [RESOURCES-1:0][AMT_W-1:0] pool_q;
  logic [ROWS-1:0][AMT_W-1:0]  held_q;
  logic [ROWS-1:0][AMT_W-1:0]  claim_q;
  status_e                     status_q;
  logic [FAIL_W-1:0]           fail_q;

  mode_e                       mode_q;
  logic [CUST_W-1:0]           cust_q;
  logic [RESOURCES-1:0][AMT_W-1:0] amt_q;

  logic [AMT_N-1:0][AMT_W-1:0] amt_in;
  logic                        accept;
  logic                        in_range;
  logic                        last;
  logic [ROW_W-1:0]            row;
  amt_t                        a, p, h, c;
  logic [AMT_W:0]              sum_p, sum_h, sum_c;
  amt_t                        sat_p, sat_h, sat_c;

  assign amt_in = {req_i.amount_3, req_i.amount_2, req_i.amount_1, req_i.amount_0};
  assign accept = req_i.valid && req_i.ready;
  assign in_range = 32'(req_i.customer) < CUSTOMERS;
  assign last = r_q == IDX_W'(RESOURCES - 1);
  assign row = ROW_W'(32'(cust_q) * RESOURCES + 32'(r_q));

  // shared unit operands
  assign a = amt_q[r_q];
  assign p = pool_q[r_q];
  assign h = held_q[row];
  assign c = claim_q[row];

  assign sum_p = {1'b0, p} + {1'b0, a};
  assign sum_h = {1'b0, h} + {1'b0, a};
  assign sum_c = {1'b0, c} + {1'b0, a};
  assign sat_p = sum_p[AMT_W] ? '1 : sum_p[AMT_W-1:0];
  assign sat_h = sum_h[AMT_W] ? '1 : sum_h[AMT_W-1:0];
  assign sat_c = sum_c[AMT_W] ? '1 : sum_c[AMT_W-1:0];

  assign req_i.ready = state_q == ST_IDLE;
  assign rsp_o.valid = state_q == ST_RESP;
  assign rsp_o.status = status_q;
  assign rsp_o.failing_resource = fail_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_e'(req_i.mode);
      cust_q <= req_i.customer;
      for (int i = 0; i < RESOURCES; i++) begin
        amt_q[i] <= amt_in[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      r_q      <= '0;
      pool_q   <= '0;
      held_q   <= '0;
      claim_q  <= '0;
      status_q <= STAT_DONE;
      fail_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            r_q      <= '0;
            status_q <= STAT_DONE;
            fail_q   <= '0;
            if (mode_e'(req_i.mode) == MODE_LOAD_POOL) begin
              state_q <= ST_UPDATE;
            end else if (!in_range) begin
              state_q <= ST_RESP;
            end else if (mode_e'(req_i.mode) == MODE_LOAD_MAX) begin
              state_q <= ST_UPDATE;
            end else begin
              state_q <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          priority if (mode_q == MODE_REQUEST && a > p) begin
            status_q <= STAT_AVAIL;
            fail_q   <= FAIL_W'(r_q);
            state_q  <= ST_RESP;
          end else if (mode_q == MODE_REQUEST && a > c) begin
            status_q <= STAT_NEED;
            fail_q   <= FAIL_W'(r_q);
            state_q  <= ST_RESP;
          end else if (mode_q == MODE_RELEASE && a > h) begin
            status_q <= STAT_ALLOC;
            fail_q   <= FAIL_W'(r_q);
            state_q  <= ST_RESP;
          end else if (last) begin
            r_q     <= '0;
            state_q <= ST_UPDATE;
          end else begin
            r_q <= r_q + 1'b1;
          end
        end
        ST_UPDATE: begin
          unique case (mode_q)
            MODE_REQUEST: begin
              pool_q[r_q]  <= p - a;
              held_q[row]  <= sat_h;
              claim_q[row] <= c - a;
            end
            MODE_RELEASE: begin
              pool_q[r_q]  <= sat_p;
              held_q[row]  <= h - a;
              claim_q[row] <= sat_c;
            end
            MODE_LOAD_MAX: begin
              held_q[row]  <= '0;
              claim_q[row] <= a;
            end
            MODE_LOAD_POOL: begin
              pool_q[r_q] <= a;
            end
            default: ;
          endcase
          if (last) begin
            state_q <= ST_RESP;
          end else begin
            r_q <= r_q + 1'b1;
          end
        end
        ST_RESP: begin
          if (rsp_o.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // tables only move during the update sweep
  a_tables_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_UPDATE |=> $stable(pool_q) && $stable(held_q) && $stable(claim_q))
    else $error("ledger tables changed outside update");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.ready && rsp_o.valid))
    else $error("accepting while a response is pending");

  a_done_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && status_q == STAT_DONE |-> fail_q == '0)
    else $error("failing resource set on a done response");

  a_req_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (status_q == STAT_AVAIL || status_q == STAT_NEED)
      |-> mode_q == MODE_REQUEST)
    else $error("request status on a non-request transaction");

  a_rel_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && status_q == STAT_ALLOC |-> mode_q == MODE_RELEASE)
    else $error("allocation status on a non-release transaction");

endmodule
